// File: rtl/per_position_base_quality_stats_assert.svh
// assertion macros for the per-position base quality statistics block
// no dependencies; included by the modules that carry checks
`ifndef PER_POSITION_BASE_QUALITY_STATS_ASSERT_SVH
`define PER_POSITION_BASE_QUALITY_STATS_ASSERT_SVH
`ifndef SYNTH
`define PPBQS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("ppbqs assertion failed");
`define PPBQS_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("ppbqs forbidden condition seen");
`else
`define PPBQS_ASSERT(lbl, clk, rstn, prop)
`define PPBQS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: rtl/ppbqs_pkg.sv
// shared types and constants of the per-position base quality statistics block
// no dependencies
package ppbqs_pkg;

	localparam int POS_W      = 9;
	localparam int POS_EXT_W  = 17;
	localparam int CLASS_W    = 3;
	localparam int QUAL_W     = 7;
	localparam int CNT_OUT_W  = 32;
	localparam int QSUM_W     = 40;
	localparam int LEN_W      = 48;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam int DEF_MAX_POSITIONS = 512;
	localparam int DEF_COUNT_BITS    = 32;

	localparam logic [QUAL_W-1:0] QUAL_OFFSET = 7'd33;
	localparam logic [QUAL_W-1:0] Q20_RESET   = 7'd53;
	localparam logic [QUAL_W-1:0] Q30_RESET   = 7'd63;

	typedef enum logic [0:0] {
		KIND_BASE    = 1'b0,
		KIND_READOUT = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_Q20_LEVEL = 1'b0,
		REG_Q30_LEVEL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         base_char;
		logic [QUAL_W-1:0]  qual_char;
		logic [POS_W-1:0]   position;
		logic               last_of_read;
		logic [CLASS_W-1:0] read_class;
	} item_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] q30_count;
		logic [CNT_OUT_W-1:0] q20_count;
		logic [CNT_OUT_W-1:0] class_count;
		logic [QSUM_W-1:0]    class_qual_sum;
		logic [CNT_OUT_W-1:0] position_count;
		logic [QSUM_W-1:0]    position_qual_sum;
		logic [CNT_OUT_W-1:0] reads_seen;
		logic [LEN_W-1:0]     length_total;
	} result_t;

	typedef struct packed {
		kind_t             kind;
		logic [QUAL_W-1:0] qual;
		logic [POS_W-1:0]  pos;
		logic              last;
		logic              in_range;
	} stage_t;

	typedef struct packed {
		logic [QUAL_W-1:0] q20;
		logic [QUAL_W-1:0] q30;
	} levels_t;

endpackage

// File: rtl/per_position_base_quality_stats.sv
// per-position base quality statistics: top level, pipeline control and tables
// depends on ppbqs_pkg, ppbqs_ram, ppbqs_update, ppbqs_out_q and the assertion header
//
// usage:
// - item channel (item_valid/item_ready/item_data) takes one base or one readout
//   request per transfer; result channel (res_valid/res_ready/res_data) returns one
//   result per readout, none per base
// - one item per cycle sustained while item_ready is high: each item reads the class
//   and position tables once, a base in range writes them back in the next cycle,
//   and an item that hits the entry written just before it takes the written value
//   from a forwarding register
// - a readout's result is pushed from the update stage into the result queue
// - results wait in a two-entry queue; when the receiver stalls, item_ready drops
//   for any item once the queue could not take one more result
// - after reset both tables are swept to zero, one class-table entry per cycle,
//   over all 8 * 2^clog2(MAX_POSITIONS) class-table entries (4096 at the default);
//   item_ready stays low meanwhile, register writes are taken at any time
// - cfg_we/cfg_index/cfg_wdata write the quality levels; write only while idle
`include "per_position_base_quality_stats_assert.svh"
module per_position_base_quality_stats #(
	parameter int MAX_POSITIONS = ppbqs_pkg::DEF_MAX_POSITIONS,
	parameter int COUNT_BITS    = ppbqs_pkg::DEF_COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  ppbqs_pkg::item_t                   item_data,
	output logic                               res_valid,
	input  logic                               res_ready,
	output ppbqs_pkg::result_t                 res_data,
	input  logic                               cfg_we,
	input  logic [ppbqs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppbqs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int POS_AW     = $clog2(MAX_POSITIONS);
	localparam int CLS_AW     = POS_AW + ppbqs_pkg::CLASS_W;
	localparam int CLS_WORD_W = 3 * COUNT_BITS + ppbqs_pkg::QSUM_W;
	localparam int POS_WORD_W = COUNT_BITS + ppbqs_pkg::QSUM_W;
	localparam int PEW        = ppbqs_pkg::POS_EXT_W;

	logic                         accept;
	logic [PEW-1:0]               pos_ext;
	logic                         in_range_s0;
	logic [ppbqs_pkg::CLASS_W-1:0] cls_s0;
	logic [POS_AW-1:0]            pos_addr_s0;
	logic [CLS_AW-1:0]            cls_addr_s0;
	ppbqs_pkg::stage_t            stage_s0;

	logic                         v_s1;
	ppbqs_pkg::stage_t            stage_s1;
	logic [CLS_AW-1:0]            cls_addr_s1;
	logic [POS_AW-1:0]            pos_addr_s1;

	logic [CLS_WORD_W-1:0]        cls_rdata, cls_cur, cls_nxt, cls_wdata;
	logic [POS_WORD_W-1:0]        pos_rdata, pos_cur, pos_nxt, pos_wdata;
	logic                         upd_we, cls_we, pos_we;
	logic [CLS_AW-1:0]            cls_waddr;
	logic [POS_AW-1:0]            pos_waddr;

	logic                         fwd_v_q;
	logic [CLS_AW-1:0]            fwd_cls_addr_q;
	logic [POS_AW-1:0]            fwd_pos_addr_q;
	logic [CLS_WORD_W-1:0]        fwd_cls_data_q;
	logic [POS_WORD_W-1:0]        fwd_pos_data_q;

	logic [CLS_AW-1:0]            clr_q;
	logic                         clr_done_q;

	ppbqs_pkg::levels_t           levels_q;
	logic [COUNT_BITS-1:0]        reads_q, reads_nxt;
	logic [ppbqs_pkg::LEN_W-1:0]  len_q, len_nxt;

	ppbqs_pkg::result_t           res_s1;
	logic                         push, pop, s1_readout;
	logic [1:0]                   q_count;
	logic [2:0]                   q_occ;

	// item entry and table read
	assign accept      = item_valid && item_ready;
	assign pos_ext     = PEW'(item_data.position);
	assign in_range_s0 = pos_ext < PEW'(MAX_POSITIONS);
	assign cls_s0      = (item_data.kind == ppbqs_pkg::KIND_READOUT) ? item_data.read_class
		: item_data.base_char[ppbqs_pkg::CLASS_W-1:0];
	assign pos_addr_s0 = pos_ext[POS_AW-1:0];
	assign cls_addr_s0 = {cls_s0, pos_addr_s0};

	always_comb begin
		stage_s0.kind     = item_data.kind;
		stage_s0.qual     = item_data.qual_char;
		stage_s0.pos      = item_data.position;
		stage_s0.last     = item_data.last_of_read;
		stage_s0.in_range = in_range_s0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1    <= stage_s0;
			cls_addr_s1 <= cls_addr_s0;
			pos_addr_s1 <= pos_addr_s0;
		end
	end

	// forwarding from the write of the previous cycle
	assign cls_cur = (fwd_v_q && (fwd_cls_addr_q == cls_addr_s1)) ? fwd_cls_data_q : cls_rdata;
	assign pos_cur = (fwd_v_q && (fwd_pos_addr_q == pos_addr_s1)) ? fwd_pos_data_q : pos_rdata;

	ppbqs_update #(
		.COUNT_BITS (COUNT_BITS),
		.CLS_WORD_W (CLS_WORD_W),
		.POS_WORD_W (POS_WORD_W)
	) u_update (
		.ctl          (stage_s1),
		.levels       (levels_q),
		.cls_word     (cls_cur),
		.pos_word     (pos_cur),
		.reads_cur    (reads_q),
		.len_cur      (len_q),
		.cls_word_nxt (cls_nxt),
		.pos_word_nxt (pos_nxt),
		.reads_nxt    (reads_nxt),
		.len_nxt      (len_nxt),
		.res          (res_s1)
	);

	// write back, or clearing sweep after reset
	assign upd_we    = v_s1 && (stage_s1.kind == ppbqs_pkg::KIND_BASE) && stage_s1.in_range;
	assign cls_we    = !clr_done_q || upd_we;
	assign pos_we    = cls_we;
	assign cls_waddr = clr_done_q ? cls_addr_s1 : clr_q;
	assign pos_waddr = clr_done_q ? pos_addr_s1 : clr_q[POS_AW-1:0];
	assign cls_wdata = clr_done_q ? cls_nxt : '0;
	assign pos_wdata = clr_done_q ? pos_nxt : '0;

	ppbqs_ram #(
		.WIDTH (CLS_WORD_W),
		.DEPTH (1 << CLS_AW)
	) u_cls_ram (
		.clk   (clk),
		.we    (cls_we),
		.waddr (cls_waddr),
		.wdata (cls_wdata),
		.re    (accept),
		.raddr (cls_addr_s0),
		.rdata (cls_rdata)
	);

	ppbqs_ram #(
		.WIDTH (POS_WORD_W),
		.DEPTH (1 << POS_AW)
	) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.re    (accept),
		.raddr (pos_addr_s0),
		.rdata (pos_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q    <= 1'b0;
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			reads_q    <= '0;
			len_q      <= '0;
			levels_q.q20 <= ppbqs_pkg::Q20_RESET;
			levels_q.q30 <= ppbqs_pkg::Q30_RESET;
		end else begin
			fwd_v_q <= upd_we;
			if (!clr_done_q) begin
				clr_q <= clr_q + CLS_AW'(1);
				if (clr_q == '1) begin
					clr_done_q <= 1'b1;
				end
			end
			if (v_s1) begin
				reads_q <= reads_nxt;
				len_q   <= len_nxt;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					ppbqs_pkg::REG_Q20_LEVEL: levels_q.q20 <= cfg_wdata;
					ppbqs_pkg::REG_Q30_LEVEL: levels_q.q30 <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_we) begin
			fwd_cls_addr_q <= cls_addr_s1;
			fwd_pos_addr_q <= pos_addr_s1;
			fwd_cls_data_q <= cls_nxt;
			fwd_pos_data_q <= pos_nxt;
		end
	end

	// result queue and flow control
	assign s1_readout = v_s1 && (stage_s1.kind == ppbqs_pkg::KIND_READOUT);
	assign push       = s1_readout;
	assign pop        = res_valid && res_ready;
	assign q_occ      = 3'(q_count) + 3'(s1_readout);
	assign item_ready = clr_done_q && (q_occ <= 3'd1 + 3'(pop));

	ppbqs_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_s1),
		.valid     (res_valid),
		.ready     (res_ready),
		.data      (res_data),
		.count     (q_count)
	);

	`PPBQS_ASSERT(a_s1_from_transfer, clk, arst_n, v_s1 |-> $past(accept))
	`PPBQS_ASSERT(a_fwd_from_base, clk, arst_n, fwd_v_q |-> $past(v_s1))
	`PPBQS_ASSERT(a_clear_quiet, clk, arst_n, $rose(clr_done_q) |-> (q_count == 2'd0) && !v_s1)

endmodule

// File: rtl/ppbqs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ppbqs_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/ppbqs_update.sv
// read-modify-write datapath: saturating counter updates and result assembly
// depends on ppbqs_pkg
module ppbqs_update #(
	parameter int COUNT_BITS = ppbqs_pkg::DEF_COUNT_BITS,
	parameter int CLS_WORD_W = 3 * COUNT_BITS + ppbqs_pkg::QSUM_W,
	parameter int POS_WORD_W = COUNT_BITS + ppbqs_pkg::QSUM_W
) (
	input  ppbqs_pkg::stage_t                ctl,
	input  ppbqs_pkg::levels_t               levels,
	input  logic [CLS_WORD_W-1:0]            cls_word,
	input  logic [POS_WORD_W-1:0]            pos_word,
	input  logic [COUNT_BITS-1:0]            reads_cur,
	input  logic [ppbqs_pkg::LEN_W-1:0]      len_cur,
	output logic [CLS_WORD_W-1:0]            cls_word_nxt,
	output logic [POS_WORD_W-1:0]            pos_word_nxt,
	output logic [COUNT_BITS-1:0]            reads_nxt,
	output logic [ppbqs_pkg::LEN_W-1:0]      len_nxt,
	output ppbqs_pkg::result_t               res
);

	localparam int QW = ppbqs_pkg::QSUM_W;
	localparam int LW = ppbqs_pkg::LEN_W;
	localparam int PW = ppbqs_pkg::POS_W;

	logic [COUNT_BITS-1:0] q30_cur, q20_cur, ccnt_cur, pcnt_cur;
	logic [QW-1:0]         cqs_cur, pqs_cur;
	logic [COUNT_BITS-1:0] q30_nxt, q20_nxt, ccnt_nxt, pcnt_nxt;
	logic [QW-1:0]         cqs_nxt, pqs_nxt;
	logic [COUNT_BITS:0]   q30_sum, q20_sum, ccnt_sum, pcnt_sum, reads_sum;
	logic [QW:0]           cqs_sum, pqs_sum;
	logic [LW:0]           len_sum;
	logic [PW:0]           pos_plus;
	logic                  q30_hit, q20_hit, ends_read;
	logic [ppbqs_pkg::QUAL_W-1:0] score;

	assign {q30_cur, q20_cur, ccnt_cur, cqs_cur} = cls_word;
	assign {pcnt_cur, pqs_cur} = pos_word;

	assign q30_hit = ctl.qual >= levels.q30;
	assign q20_hit = q30_hit || (ctl.qual >= levels.q20);
	assign score   = (ctl.qual >= ppbqs_pkg::QUAL_OFFSET) ? ctl.qual - ppbqs_pkg::QUAL_OFFSET
		: '0;

	// saturation: the carry out of a widened add means the limit was passed
	assign q30_sum  = {1'b0, q30_cur} + (COUNT_BITS+1)'(q30_hit);
	assign q20_sum  = {1'b0, q20_cur} + (COUNT_BITS+1)'(q20_hit);
	assign ccnt_sum = {1'b0, ccnt_cur} + (COUNT_BITS+1)'(1);
	assign pcnt_sum = {1'b0, pcnt_cur} + (COUNT_BITS+1)'(1);
	assign cqs_sum  = {1'b0, cqs_cur} + (QW+1)'(score);
	assign pqs_sum  = {1'b0, pqs_cur} + (QW+1)'(score);

	assign q30_nxt  = q30_sum[COUNT_BITS]  ? '1 : q30_sum[COUNT_BITS-1:0];
	assign q20_nxt  = q20_sum[COUNT_BITS]  ? '1 : q20_sum[COUNT_BITS-1:0];
	assign ccnt_nxt = ccnt_sum[COUNT_BITS] ? '1 : ccnt_sum[COUNT_BITS-1:0];
	assign pcnt_nxt = pcnt_sum[COUNT_BITS] ? '1 : pcnt_sum[COUNT_BITS-1:0];
	assign cqs_nxt  = cqs_sum[QW] ? '1 : cqs_sum[QW-1:0];
	assign pqs_nxt  = pqs_sum[QW] ? '1 : pqs_sum[QW-1:0];

	assign cls_word_nxt = {q30_nxt, q20_nxt, ccnt_nxt, cqs_nxt};
	assign pos_word_nxt = {pcnt_nxt, pqs_nxt};

	// read totals
	assign ends_read = (ctl.kind == ppbqs_pkg::KIND_BASE) && ctl.last;
	assign pos_plus  = (PW+1)'(ctl.pos) + (PW+1)'(1);
	assign reads_sum = {1'b0, reads_cur} + (COUNT_BITS+1)'(1);
	assign len_sum   = {1'b0, len_cur} + (LW+1)'(pos_plus);

	always_comb begin
		reads_nxt = reads_cur;
		len_nxt   = len_cur;
		if (ends_read) begin
			reads_nxt = reads_sum[COUNT_BITS] ? '1 : reads_sum[COUNT_BITS-1:0];
			len_nxt   = len_sum[LW] ? '1 : len_sum[LW-1:0];
		end
	end

	always_comb begin
		res = '0;
		if (ctl.in_range) begin
			res.q30_count         = ppbqs_pkg::CNT_OUT_W'(q30_cur);
			res.q20_count         = ppbqs_pkg::CNT_OUT_W'(q20_cur);
			res.class_count       = ppbqs_pkg::CNT_OUT_W'(ccnt_cur);
			res.class_qual_sum    = cqs_cur;
			res.position_count    = ppbqs_pkg::CNT_OUT_W'(pcnt_cur);
			res.position_qual_sum = pqs_cur;
		end
		res.reads_seen   = ppbqs_pkg::CNT_OUT_W'(reads_cur);
		res.length_total = len_cur;
	end

endmodule

// File: rtl/ppbqs_out_q.sv
// two-entry result queue between the update stage and the result channel
// depends on ppbqs_pkg and the assertion header
`include "per_position_base_quality_stats_assert.svh"
module ppbqs_out_q (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ppbqs_pkg::result_t push_data,
	output logic               valid,
	input  logic               ready,
	output ppbqs_pkg::result_t data,
	output logic [1:0]         count
);

	ppbqs_pkg::result_t entry_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         count_q;
	logic               pop;

	assign valid = count_q != 2'd0;
	assign data  = entry_q[rd_ptr_q];
	assign count = count_q;
	assign pop   = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`PPBQS_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && (count_q == 2'd2) && !pop)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// testbench for per_position_base_quality_stats: directed and random base and readout
// transfers, each readout checked field by field against an in-bench copy of the tables
// depends on ppbqs_pkg and the rtl of the block
module tb;

	localparam int NUM_CLASSES = 8;
	localparam int NUM_POS     = ppbqs_pkg::DEF_MAX_POSITIONS;
	localparam int CW          = ppbqs_pkg::CNT_OUT_W;
	localparam int QW          = ppbqs_pkg::QSUM_W;
	localparam int LW          = ppbqs_pkg::LEN_W;
	localparam int QLW         = ppbqs_pkg::QUAL_W;
	localparam int PW          = ppbqs_pkg::POS_W;
	localparam int CLW         = ppbqs_pkg::CLASS_W;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam longint unsigned CNT_TOP  = (64'd1 << ppbqs_pkg::DEF_COUNT_BITS) - 1;
	localparam longint unsigned QSUM_TOP = (64'd1 << QW) - 1;
	localparam longint unsigned LEN_TOP  = (64'd1 << LW) - 1;

	logic                                clk;
	logic                                arst_n;
	logic                                item_valid;
	logic                                item_ready;
	ppbqs_pkg::item_t                    item_data;
	logic                                res_valid;
	logic                                res_ready;
	ppbqs_pkg::result_t                  res_data;
	logic                                cfg_we;
	logic [ppbqs_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [ppbqs_pkg::CFG_DATA_W-1:0]    cfg_wdata;

	// model of the block's counters
	logic [QLW-1:0]     lvl_q20;
	logic [QLW-1:0]     lvl_q30;
	bit [CW-1:0]        tab_q30      [NUM_CLASSES][NUM_POS];
	bit [CW-1:0]        tab_q20      [NUM_CLASSES][NUM_POS];
	bit [CW-1:0]        tab_cls_cnt  [NUM_CLASSES][NUM_POS];
	bit [QW-1:0]        tab_cls_qsum [NUM_CLASSES][NUM_POS];
	bit [CW-1:0]        tab_pos_cnt  [NUM_POS];
	bit [QW-1:0]        tab_pos_qsum [NUM_POS];
	bit [CW-1:0]        reads_done;
	bit [LW-1:0]        len_sum;
	ppbqs_pkg::result_t pending_results [$];

	bit sender_gaps;
	bit receiver_stalls;
	int hold_len;
	int quiet_cycles;
	int mismatches;
	int n_bases;
	int n_readouts;
	int n_results;

	per_position_base_quality_stats i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_data  (item_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned add,
		longint unsigned lim);
		if (acc >= lim || add > lim - acc)
			return lim;
		return acc + add;
	endfunction

	function automatic void tally_base(ppbqs_pkg::item_t it);
		logic [CLW-1:0]  cls;
		logic [PW-1:0]   p;
		longint unsigned score;
		cls   = it.base_char[CLW-1:0];
		p     = it.position;
		score = (it.qual_char >= ppbqs_pkg::QUAL_OFFSET) ?
			64'(it.qual_char - ppbqs_pkg::QUAL_OFFSET) : 64'd0;
		if (p < NUM_POS) begin
			if (it.qual_char >= lvl_q30) begin
				tab_q30[cls][p] = CW'(sat_sum(tab_q30[cls][p], 1, CNT_TOP));
				tab_q20[cls][p] = CW'(sat_sum(tab_q20[cls][p], 1, CNT_TOP));
			end else if (it.qual_char >= lvl_q20) begin
				tab_q20[cls][p] = CW'(sat_sum(tab_q20[cls][p], 1, CNT_TOP));
			end
			tab_cls_cnt[cls][p]  = CW'(sat_sum(tab_cls_cnt[cls][p], 1, CNT_TOP));
			tab_cls_qsum[cls][p] = QW'(sat_sum(tab_cls_qsum[cls][p], score, QSUM_TOP));
			tab_pos_cnt[p]       = CW'(sat_sum(tab_pos_cnt[p], 1, CNT_TOP));
			tab_pos_qsum[p]      = QW'(sat_sum(tab_pos_qsum[p], score, QSUM_TOP));
		end
		if (it.last_of_read) begin
			reads_done = CW'(sat_sum(reads_done, 1, CNT_TOP));
			len_sum    = LW'(sat_sum(len_sum, 64'(p) + 64'd1, LEN_TOP));
		end
	endfunction

	function automatic ppbqs_pkg::result_t lookup_counters(ppbqs_pkg::item_t it);
		ppbqs_pkg::result_t r;
		r = '0;
		if (it.position < NUM_POS) begin
			r.q30_count         = tab_q30[it.read_class][it.position];
			r.q20_count         = tab_q20[it.read_class][it.position];
			r.class_count       = tab_cls_cnt[it.read_class][it.position];
			r.class_qual_sum    = tab_cls_qsum[it.read_class][it.position];
			r.position_count    = tab_pos_cnt[it.position];
			r.position_qual_sum = tab_pos_qsum[it.position];
		end
		r.reads_seen   = reads_done;
		r.length_total = len_sum;
		return r;
	endfunction

	function automatic ppbqs_pkg::item_t base_item(logic [7:0] letter, logic [QLW-1:0] qual,
		logic [PW-1:0] pos, logic last);
		ppbqs_pkg::item_t it;
		it.kind         = ppbqs_pkg::KIND_BASE;
		it.base_char    = letter;
		it.qual_char    = qual;
		it.position     = pos;
		it.last_of_read = last;
		it.read_class   = CLW'($urandom_range(0, NUM_CLASSES - 1));
		return it;
	endfunction

	function automatic ppbqs_pkg::item_t readout_item(logic [PW-1:0] pos, logic [CLW-1:0] cls);
		ppbqs_pkg::item_t it;
		it.kind         = ppbqs_pkg::KIND_READOUT;
		it.base_char    = 8'($urandom);
		it.qual_char    = QLW'($urandom);
		it.position     = pos;
		it.last_of_read = 1'($urandom);
		it.read_class   = cls;
		return it;
	endfunction

	function automatic logic [7:0] random_letter();
		string alphabet;
		alphabet = "ACGTN";
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		return alphabet[$urandom_range(0, 4)];
	endfunction

	function automatic logic [QLW-1:0] random_qual();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return QLW'($urandom_range(33, 74));
		if (pick == 6)
			return lvl_q20 + QLW'($urandom_range(0, 2)) - 7'd1;
		if (pick == 7)
			return lvl_q30 + QLW'($urandom_range(0, 2)) - 7'd1;
		return QLW'($urandom);
	endfunction

	task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch %s at %0t: got %0h, expected %0h", what, $time, got, want);
	endtask

	// entered and left at a falling edge
	task automatic send_item(ppbqs_pkg::item_t it);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_data  <= it;
		do begin
			@(posedge clk);
		end while (!item_ready);
		if (it.kind == ppbqs_pkg::KIND_BASE) begin
			tally_base(it);
			n_bases++;
		end else begin
			pending_results = {pending_results, lookup_counters(it)};
			n_readouts++;
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_levels(logic [QLW-1:0] q20, logic [QLW-1:0] q30);
		cfg_we    <= 1'b1;
		cfg_index <= ppbqs_pkg::REG_Q20_LEVEL;
		cfg_wdata <= q20;
		@(negedge clk);
		cfg_index <= ppbqs_pkg::REG_Q30_LEVEL;
		cfg_wdata <= q30;
		@(negedge clk);
		cfg_we  <= 1'b0;
		lvl_q20 = q20;
		lvl_q30 = q30;
		@(negedge clk);
	endtask

	task automatic stream_traffic(int target);
		int            sent;
		int            len;
		int            pick;
		logic [PW-1:0] pos;
		logic [7:0]    letter;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
				for (int p = 0; p < len; p++)
					send_item(base_item(random_letter(), random_qual(), PW'(p), p == len - 1));
				sent += len;
			end else if (pick < 8) begin
				pos = ($urandom_range(0, 3) == 0) ? PW'($urandom) : PW'($urandom_range(0, 24));
				send_item(readout_item(pos, CLW'($urandom)));
				sent++;
			end else if (pick == 8) begin
				// same entry hit by several bases in a row, then read out by the next item
				pos    = PW'($urandom_range(0, 24));
				letter = random_letter();
				len    = $urandom_range(2, 6);
				repeat (len) send_item(base_item(letter, random_qual(), pos, 1'b0));
				send_item(readout_item(pos, letter[CLW-1:0]));
				sent += len + 1;
			end else begin
				send_item(base_item(8'($urandom), QLW'($urandom), PW'($urandom),
					1'($urandom)));
				sent++;
			end
		end
	endtask

	task automatic test_directed_extremes();
		send_item(readout_item(9'd0, 3'd0));
		send_item(base_item("A", 7'd63, 9'd0, 1'b0));
		send_item(base_item("C", 7'd62, 9'd0, 1'b0));
		send_item(base_item("G", 7'd53, 9'd0, 1'b0));
		send_item(base_item("T", 7'd52, 9'd0, 1'b0));
		send_item(base_item("N", 7'd32, 9'd0, 1'b0));
		send_item(base_item(8'h00, 7'd0, 9'd0, 1'b0));
		send_item(base_item(8'hff, 7'd127, 9'd511, 1'b1));
		send_item(base_item("A", 7'd33, 9'd511, 1'b0));
		send_item(base_item("A", 7'd126, 9'd0, 1'b1));
		send_item(base_item("A", 7'd126, 9'd0, 1'b0));
		for (int c = 0; c < NUM_CLASSES; c++)
			send_item(readout_item(9'd0, CLW'(c)));
		send_item(readout_item(9'd511, 3'd7));
		send_item(readout_item(9'd511, 3'd1));
		send_item(readout_item(9'd255, 3'd5));
	endtask

	task automatic test_level_settings();
		logic [QLW-1:0] lv20 [5];
		logic [QLW-1:0] lv30 [5];
		logic [QLW-1:0] quals [9];
		logic [PW-1:0]  pos;
		lv20  = '{7'd33, 7'd126, 7'd0, 7'd127, ppbqs_pkg::Q20_RESET};
		lv30  = '{7'd126, 7'd33, 7'd127, 7'd0, ppbqs_pkg::Q30_RESET};
		quals = '{7'd0, 7'd32, 7'd33, 7'd34, 7'd62, 7'd63, 7'd64, 7'd126, 7'd127};
		for (int k = 0; k < 5; k++) begin
			drain_results();
			set_levels(lv20[k], lv30[k]);
			pos = PW'(100 + k);
			foreach (quals[j])
				send_item(base_item("G", quals[j], pos, 1'b0));
			send_item(base_item("T", QLW'($urandom), pos, 1'b1));
			send_item(readout_item(pos, 3'd7));
			send_item(readout_item(pos, 3'd4));
			send_item(readout_item(pos, 3'd0));
		end
	endtask

	task automatic test_random_reads();
		for (int k = 0; k < 3; k++) begin
			drain_results();
			set_levels(QLW'($urandom_range(33, 126)), QLW'($urandom_range(33, 126)));
			stream_traffic(280);
		end
	endtask

	task automatic test_result_backpressure();
		drain_results();
		sender_gaps = 1'b0;
		hold_len    = HOLD_CYCLES;
		for (int i = 0; i < 48; i++) begin
			if (i % 4 == 3)
				send_item(base_item(random_letter(), random_qual(), PW'($urandom_range(0, 24)),
					1'b0));
			else
				send_item(readout_item(PW'($urandom_range(0, 24)), CLW'($urandom)));
		end
		sender_gaps = 1'b1;
		drain_results();
	endtask

	task automatic test_steady_stream();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		stream_traffic(120);
		drain_results();
	endtask

	// receiver side: random stalls and one long hold-off on request
	initial begin
		int span;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				span     = hold_len;
				hold_len = 0;
				res_ready <= 1'b0;
				repeat (span - 1) @(negedge clk);
			end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		ppbqs_pkg::result_t want;
		if (res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", 0, 0);
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (res_data.q30_count !== want.q30_count)
					note_mismatch("q30_count", res_data.q30_count, want.q30_count);
				if (res_data.q20_count !== want.q20_count)
					note_mismatch("q20_count", res_data.q20_count, want.q20_count);
				if (res_data.class_count !== want.class_count)
					note_mismatch("class_count", res_data.class_count, want.class_count);
				if (res_data.class_qual_sum !== want.class_qual_sum)
					note_mismatch("class_qual_sum", res_data.class_qual_sum, want.class_qual_sum);
				if (res_data.position_count !== want.position_count)
					note_mismatch("position_count", res_data.position_count, want.position_count);
				if (res_data.position_qual_sum !== want.position_qual_sum)
					note_mismatch("position_qual_sum", res_data.position_qual_sum,
						want.position_qual_sum);
				if (res_data.reads_seen !== want.reads_seen)
					note_mismatch("reads_seen", res_data.reads_seen, want.reads_seen);
				if (res_data.length_total !== want.length_total)
					note_mismatch("length_total", res_data.length_total, want.length_total);
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("[per_position_base_quality_stats] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item_data       = '0;
		cfg_we          = 1'b0;
		cfg_index       = ppbqs_pkg::REG_Q20_LEVEL;
		cfg_wdata       = '0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		hold_len        = 0;
		lvl_q20         = ppbqs_pkg::Q20_RESET;
		lvl_q30         = ppbqs_pkg::Q30_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_extremes();
		test_level_settings();
		test_random_reads();
		test_result_backpressure();
		test_steady_stream();
		$display("covered %0d bases and %0d readouts, %0d results checked, %0d mismatches",
			n_bases, n_readouts, n_results, mismatches);
		$display("levels swept incl. inverted and extreme pairs; receiver held off %0d cycles",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("[per_position_base_quality_stats] OK");
		else
			$display("[per_position_base_quality_stats] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ppbqs_pkg.sv
rtl/ppbqs_ram.sv
rtl/ppbqs_update.sv
rtl/ppbqs_out_q.sv
rtl/per_position_base_quality_stats.sv
verif/tb.sv
